// File: hdl/process_policy_table_macros.svh
// Assertion macros for the process policy table.
// Included by process_policy_table.sv; no other dependencies.
`ifndef PROCESS_POLICY_TABLE_MACROS_SVH
`define PROCESS_POLICY_TABLE_MACROS_SVH
`ifndef SYNTHESIS
`define PPT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("process_policy_table: same-cycle check failed");
`define PPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("process_policy_table: next-cycle check failed");
`else
`define PPT_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define PPT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: hdl/ppt_pkg.sv
// Shared types and constants for the process policy table.
// No dependencies; imported by every module of the block.
`default_nettype none
package ppt_pkg;

	localparam int CNT_W = 5;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	typedef enum logic [1:0] {
		OP_CLASSIFY = 2'd0,
		OP_UPDATE   = 2'd1,
		OP_CLEAR    = 2'd2,
		OP_QUERY    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_NO_ROOM = 2'd2
	} status_t;

	typedef enum logic {
		CFG_VERSION  = 1'b0,
		CFG_CALLOUTS = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		op_t         op;
		logic        reject;
		logic [31:0] key;
		logic [31:0] flags;
		logic [31:0] addr;
		logic [15:0] port;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	typedef struct packed {
		logic             done;
		status_t          status;
		logic             block;
		logic [CNT_W-1:0] valid_count;
		logic [1:0]       callout_count;
		logic [31:0]      change_count;
		logic [31:0]      reported_version;
	} result_t;

endpackage
`default_nettype wire

// File: hdl/ppt_front.sv
// Front end: accepts items and classifies them into queue jobs.
// Depends on ppt_pkg.
`default_nettype none
module ppt_front
	import ppt_pkg::*;
(
	input  wire logic        start,
	input  wire qstat_t      qstat,
	input  wire logic [1:0]  operation,
	input  wire logic        pid_present,
	input  wire logic [31:0] process_id,
	input  wire logic [31:0] request_version,
	input  wire logic [31:0] policy_flags,
	input  wire logic [31:0] proxy_address,
	input  wire logic [15:0] proxy_port,
	input  wire logic [31:0] version,
	output logic             busy,
	output logic             push,
	output job_t             job
);

	op_t  op;
	logic bad_ver;
	logic zero_pid;

	always_comb begin
		op       = op_t'(operation);
		bad_ver  = (request_version != version);
		zero_pid = (process_id == 32'd0);
		busy     = qstat.full;
		push     = start && !qstat.full;
		job.op    = op;
		job.key   = (op == OP_CLASSIFY && !pid_present) ? 32'd0 : process_id;
		job.flags = policy_flags;
		job.addr  = proxy_address;
		job.port  = proxy_port;
		case (op)
			OP_UPDATE: job.reject = bad_ver || zero_pid || (proxy_port == 16'd0);
			OP_CLEAR:  job.reject = bad_ver || zero_pid;
			default:   job.reject = 1'b0;
		endcase
	end

endmodule
`default_nettype wire

// File: hdl/ppt_queue.sv
// Two-item job queue between the front end and the table engine.
// Depends on ppt_pkg.
`default_nettype none
module ppt_queue
	import ppt_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t push_job,
	input  wire logic pop,
	output job_t      head,
	output qstat_t    qstat
);

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	always_comb begin
		qstat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
		qstat.empty = (count_q == '0);
		head        = mem_q[rd_ptr_q];
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: hdl/ppt_engine.sv
// Table engine: scans the entries one per cycle, applies the job, drives the result.
// Depends on ppt_pkg.
`default_nettype none
module ppt_engine
	import ppt_pkg::*;
#(
	parameter int TABLE_ENTRIES = 16
)(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        job_valid,
	input  wire job_t        job,
	input  wire logic [31:0] version,
	input  wire logic [1:0]  callouts,
	output logic             pop,
	output result_t          res
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_APPLY
	} state_t;

	state_t             state_q;
	job_t               job_q;
	logic [IDX_W-1:0]   idx_q;
	logic               hit_q;
	logic [IDX_W-1:0]   hit_idx_q;
	logic               free_q;
	logic [IDX_W-1:0]   free_idx_q;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [CNT_W-1:0]   used_q;
	logic [31:0]        gen_q;

	logic [31:0]        pid_q   [TABLE_ENTRIES];
	logic [31:0]        flags_q [TABLE_ENTRIES];
	logic [31:0]        addr_q  [TABLE_ENTRIES];
	logic [15:0]        port_q  [TABLE_ENTRIES];

	logic               cur_match;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_slot;
	result_t            apply_res;

	always_comb begin
		pop       = (state_q == S_IDLE) && job_valid;
		cur_match = valid_q[idx_q] && (pid_q[idx_q] == job_q.key);
		wr_en     = (state_q == S_APPLY) && !job_q.reject && (job_q.op == OP_UPDATE)
			&& (hit_q || free_q);
		wr_slot   = hit_q ? hit_idx_q : free_idx_q;
	end

	always_comb begin
		apply_res      = '0;
		apply_res.done = 1'b1;
		if (job_q.reject) begin
			apply_res.status = ST_INVALID;
		end else begin
			case (job_q.op)
				OP_CLASSIFY: apply_res.block = hit_q;
				OP_UPDATE: begin
					if (!(hit_q || free_q)) begin
						apply_res.status = ST_NO_ROOM;
					end
				end
				OP_CLEAR: apply_res.status = ST_OK;
				default: begin
					apply_res.valid_count      = used_q;
					apply_res.callout_count    = callouts;
					apply_res.change_count     = gen_q;
					apply_res.reported_version = version;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			pid_q[wr_slot]   <= job_q.key;
			flags_q[wr_slot] <= job_q.flags;
			addr_q[wr_slot]  <= job_q.addr;
			port_q[wr_slot]  <= job_q.port;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			job_q      <= '0;
			idx_q      <= '0;
			hit_q      <= 1'b0;
			hit_idx_q  <= '0;
			free_q     <= 1'b0;
			free_idx_q <= '0;
			valid_q    <= '0;
			used_q     <= '0;
			gen_q      <= '0;
			res        <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					res.done <= 1'b0;
					if (job_valid) begin
						job_q  <= job;
						idx_q  <= '0;
						hit_q  <= 1'b0;
						free_q <= 1'b0;
						if (job.reject || job.op == OP_QUERY) begin
							state_q <= S_APPLY;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					res.done <= 1'b0;
					if (cur_match) begin
						hit_q     <= 1'b1;
						hit_idx_q <= idx_q;
						state_q   <= S_APPLY;
					end else begin
						if (!valid_q[idx_q] && !free_q) begin
							free_q     <= 1'b1;
							free_idx_q <= idx_q;
						end
						if (idx_q == IDX_W'(TABLE_ENTRIES - 1)) begin
							state_q <= S_APPLY;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				S_APPLY: begin
					state_q <= S_IDLE;
					res     <= apply_res;
					if (!job_q.reject) begin
						case (job_q.op)
							OP_UPDATE: begin
								if (hit_q || free_q) begin
									valid_q[wr_slot] <= 1'b1;
									if (!hit_q) begin
										used_q <= used_q + 1'b1;
									end
									gen_q <= gen_q + 32'd1;
								end
							end
							OP_CLEAR: begin
								if (hit_q) begin
									valid_q[hit_idx_q] <= 1'b0;
									used_q <= used_q - 1'b1;
									gen_q  <= gen_q + 32'd1;
								end
							end
							default: begin
							end
						endcase
					end
				end
				default: begin
					res.done <= 1'b0;
					state_q  <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// File: hdl/process_policy_table.sv
// Process policy table: entries keyed by process id; classify, update, clear, query.
// Query and rejected items skip the table scan; classify, update and clear scan the
// table first. The engine takes one item at a time; further items wait in the queue.
// Reset: all entries free, counters zero, protocol_version 1, registered_callouts 0.
// Results are a one-cycle strobe; the receiver cannot stall.
`default_nettype none
`include "process_policy_table_macros.svh"
module process_policy_table
	import ppt_pkg::*;
#(
	parameter int TABLE_ENTRIES = 16
)(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  operation,
	input  wire logic        pid_present,
	input  wire logic [31:0] process_id,
	input  wire logic [31:0] request_version,
	input  wire logic [31:0] policy_flags,
	input  wire logic [31:0] proxy_address,
	input  wire logic [15:0] proxy_port,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data,
	output logic             done,
	output logic [1:0]       status,
	output logic             block,
	output logic [4:0]       valid_count,
	output logic [1:0]       callout_count,
	output logic [31:0]      change_count,
	output logic [31:0]      reported_version
);

	logic [31:0] version_q;
	logic [1:0]  callouts_q;
	qstat_t      qstat;
	logic        push;
	logic        pop;
	job_t        push_job;
	job_t        head;
	result_t     res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			version_q  <= 32'd1;
			callouts_q <= 2'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_VERSION:  version_q  <= cfg_data;
				CFG_CALLOUTS: callouts_q <= cfg_data[1:0];
				default:      version_q  <= version_q;
			endcase
		end
	end

	ppt_front u_front (
		.start           (start),
		.qstat           (qstat),
		.operation       (operation),
		.pid_present     (pid_present),
		.process_id      (process_id),
		.request_version (request_version),
		.policy_flags    (policy_flags),
		.proxy_address   (proxy_address),
		.proxy_port      (proxy_port),
		.version         (version_q),
		.busy            (busy),
		.push            (push),
		.job             (push_job)
	);

	ppt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.qstat    (qstat)
	);

	ppt_engine #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (!qstat.empty),
		.job       (head),
		.version   (version_q),
		.callouts  (callouts_q),
		.pop       (pop),
		.res       (res)
	);

	assign done             = res.done;
	assign status           = res.status;
	assign block            = res.block;
	assign valid_count      = res.valid_count;
	assign callout_count    = res.callout_count;
	assign change_count     = res.change_count;
	assign reported_version = res.reported_version;

	`PPT_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done)
	`PPT_ASSERT_SAME(a_busy_has_work, clk, arst_n, busy, !qstat.empty)
	`PPT_ASSERT_SAME(a_block_is_ok, clk, arst_n, done && block, status == ST_OK && change_count == '0)

endmodule
`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Testbench for process_policy_table: a directed request table, then random requests
// in bursts over several register settings; every result is checked in order.
// Depends on ppt_pkg and the process_policy_table RTL.
module tb_top;
	import ppt_pkg::*;

	localparam int ENTRIES = 16;
	localparam int RANDOM_ITEMS = 1950;
	localparam int PHASES = 5;
	localparam int PID_POOL = 24;

	typedef struct packed {
		op_t         op;
		logic        present;
		logic [31:0] pid;
		logic [31:0] ver;
		logic [31:0] flags;
		logic [31:0] addr;
		logic [15:0] port;
	} req_t;

	typedef struct packed {
		status_t     st;
		logic        blk;
		logic [4:0]  vcnt;
		logic [1:0]  ccnt;
		logic [31:0] gen;
		logic [31:0] ver;
	} resp_t;

	typedef struct {
		req_t  rq;
		bit    typed;
		resp_t exp;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  operation;
	logic        pid_present;
	logic [31:0] process_id;
	logic [31:0] request_version;
	logic [31:0] policy_flags;
	logic [31:0] proxy_address;
	logic [15:0] proxy_port;
	logic        cfg_valid;
	logic        cfg_ready;
	cfg_idx_t    cfg_index;
	logic [31:0] cfg_data;
	logic        done;
	logic [1:0]  status;
	logic        block;
	logic [4:0]  valid_count;
	logic [1:0]  callout_count;
	logic [31:0] change_count;
	logic [31:0] reported_version;

	// table model
	logic        tbl_valid [ENTRIES];
	logic [31:0] tbl_pid [ENTRIES];
	logic [31:0] gen_count;
	logic [4:0]  used_entries;
	logic [31:0] cur_version;
	logic [1:0]  cur_callouts;

	resp_t pending_resp[$];
	int    failures;

	process_policy_table #(.TABLE_ENTRIES(ENTRIES)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.pid_present(pid_present),
		.process_id(process_id),
		.request_version(request_version),
		.policy_flags(policy_flags),
		.proxy_address(proxy_address),
		.proxy_port(proxy_port),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.status(status),
		.block(block),
		.valid_count(valid_count),
		.callout_count(callout_count),
		.change_count(change_count),
		.reported_version(reported_version)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic req_t make_req(op_t op, logic present, logic [31:0] pid,
		logic [31:0] ver, logic [31:0] flags, logic [31:0] addr, logic [15:0] port);
		req_t r;
		r.op = op;
		r.present = present;
		r.pid = pid;
		r.ver = ver;
		r.flags = flags;
		r.addr = addr;
		r.port = port;
		return r;
	endfunction

	function automatic resp_t make_resp(status_t st, logic blk, logic [4:0] vcnt,
		logic [1:0] ccnt, logic [31:0] gen, logic [31:0] ver);
		resp_t o;
		o.st = st;
		o.blk = blk;
		o.vcnt = vcnt;
		o.ccnt = ccnt;
		o.gen = gen;
		o.ver = ver;
		return o;
	endfunction

	function automatic int find_slot(logic [31:0] key);
		int i;
		for (i = 0; i < ENTRIES; i++)
			if (tbl_valid[i] && tbl_pid[i] == key)
				return i;
		return -1;
	endfunction

	// applies one request to the table model and returns its result
	function automatic resp_t table_response(req_t r);
		resp_t o;
		int    slot;
		int    i;
		o = make_resp(ST_OK, 1'b0, 5'd0, 2'd0, 32'd0, 32'd0);
		case (r.op)
		OP_CLASSIFY: begin
			o.blk = (find_slot(r.present ? r.pid : 32'd0) >= 0);
		end
		OP_UPDATE: begin
			if (r.ver != cur_version || r.pid == 32'd0 || r.port == 16'd0) begin
				o.st = ST_INVALID;
			end else begin
				slot = find_slot(r.pid);
				for (i = 0; i < ENTRIES && slot < 0; i++)
					if (!tbl_valid[i])
						slot = i;
				if (slot < 0) begin
					o.st = ST_NO_ROOM;
				end else begin
					if (!tbl_valid[slot])
						used_entries++;
					tbl_valid[slot] = 1'b1;
					tbl_pid[slot] = r.pid;
					gen_count++;
				end
			end
		end
		OP_CLEAR: begin
			if (r.ver != cur_version || r.pid == 32'd0) begin
				o.st = ST_INVALID;
			end else begin
				slot = find_slot(r.pid);
				if (slot >= 0) begin
					tbl_valid[slot] = 1'b0;
					used_entries--;
					gen_count++;
				end
			end
		end
		default: begin
			o.vcnt = used_entries;
			o.ccnt = cur_callouts;
			o.gen = gen_count;
			o.ver = cur_version;
		end
		endcase
		return o;
	endfunction

	function automatic req_t random_request();
		req_t r;
		int   pick;
		pick = $urandom_range(0, 99);
		if (pick < 35)
			r.op = OP_CLASSIFY;
		else if (pick < 70)
			r.op = OP_UPDATE;
		else if (pick < 90)
			r.op = OP_CLEAR;
		else
			r.op = OP_QUERY;
		r.present = ($urandom_range(0, 9) != 0);
		pick = $urandom_range(0, 99);
		if (pick < 5)
			r.pid = 32'd0;
		else if (pick < 85)
			r.pid = $urandom_range(1, PID_POOL);
		else
			r.pid = $urandom();
		r.ver = ($urandom_range(0, 9) == 0) ? $urandom() : cur_version;
		r.flags = $urandom();
		r.addr = $urandom();
		r.port = ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
		return r;
	endfunction

	// called right after a falling edge; returns right after a falling edge once the request has been taken
	task automatic issue_request(input req_t r, input bit typed, input resp_t exp);
		resp_t want;
		start = 1'b1;
		operation = r.op;
		pid_present = r.present;
		process_id = r.pid;
		request_version = r.ver;
		policy_flags = r.flags;
		proxy_address = r.addr;
		proxy_port = r.port;
		do @(posedge clk); while (busy);
		want = table_response(r);
		pending_resp.push_back(typed ? exp : want);
		@(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [31:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_VERSION)
			cur_version = data;
		else
			cur_callouts = data[1:0];
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic drain();
		start = 1'b0;
		while (pending_resp.size() != 0)
			@(negedge clk);
	endtask

	always @(posedge clk) begin : check_results
		resp_t got;
		resp_t want;
		if (arst_n && done) begin
			got = make_resp(status_t'(status), block, valid_count, callout_count,
				change_count, reported_version);
			if (pending_resp.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("%0t: unexpected result st=%0d blk=%0d vcnt=%0d ccnt=%0d gen=%h ver=%h",
						$time, got.st, got.blk, got.vcnt, got.ccnt, got.gen, got.ver);
			end else begin
				want = pending_resp.pop_front();
				if (got.st !== want.st || got.blk !== want.blk || got.vcnt !== want.vcnt ||
					got.ccnt !== want.ccnt || got.gen !== want.gen || got.ver !== want.ver) begin
					failures++;
					if (failures <= 10) begin
						$display("%0t: expected st=%0d blk=%0d vcnt=%0d ccnt=%0d gen=%h ver=%h",
							$time, want.st, want.blk, want.vcnt, want.ccnt, want.gen, want.ver);
						$display("%0t: actual   st=%0d blk=%0d vcnt=%0d ccnt=%0d gen=%h ver=%h",
							$time, got.st, got.blk, got.vcnt, got.ccnt, got.gen, got.ver);
					end
				end
			end
		end
	end

	initial begin
		row_t        dir[$];
		resp_t       inval;
		resp_t       okay;
		resp_t       none;
		int          sent;
		int          burst;
		int          phase;
		int          k;
		logic [31:0] v;
		logic [1:0]  c;

		arst_n = 1'b0;
		start = 1'b0;
		operation = OP_CLASSIFY;
		pid_present = 1'b0;
		process_id = 32'd0;
		request_version = 32'd0;
		policy_flags = 32'd0;
		proxy_address = 32'd0;
		proxy_port = 16'd0;
		cfg_valid = 1'b0;
		cfg_index = CFG_VERSION;
		cfg_data = 32'd0;
		failures = 0;
		for (k = 0; k < ENTRIES; k++) begin
			tbl_valid[k] = 1'b0;
			tbl_pid[k] = 32'd0;
		end
		gen_count = 32'd0;
		used_entries = 5'd0;
		cur_version = 32'd1;
		cur_callouts = 2'd0;

		inval = make_resp(ST_INVALID, 1'b0, 5'd0, 2'd0, 32'd0, 32'd0);
		okay = make_resp(ST_OK, 1'b0, 5'd0, 2'd0, 32'd0, 32'd0);
		none = okay;

		dir.push_back('{make_req(OP_QUERY, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 16'd0), 1'b1,
			make_resp(ST_OK, 1'b0, 5'd0, 2'd0, 32'd0, 32'd1)});
		// missing id and empty table both permit
		dir.push_back('{make_req(OP_CLASSIFY, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 16'd0),
			1'b1, okay});
		dir.push_back('{make_req(OP_CLASSIFY, 1'b1, 32'd0, 32'd1, 32'd0, 32'd0, 16'd0),
			1'b1, okay});
		dir.push_back('{make_req(OP_UPDATE, 1'b1, 32'd7, 32'd0, 32'd0, 32'd0, 16'd1),
			1'b1, inval});
		dir.push_back('{make_req(OP_UPDATE, 1'b1, 32'd7, 32'hFFFF_FFFF, 32'd0, 32'd0, 16'd1),
			1'b1, inval});
		dir.push_back('{make_req(OP_UPDATE, 1'b1, 32'd0, 32'd1, 32'd0, 32'd0, 16'd1),
			1'b1, inval});
		dir.push_back('{make_req(OP_UPDATE, 1'b1, 32'd7, 32'd1, 32'd0, 32'd0, 16'd0),
			1'b1, inval});
		dir.push_back('{make_req(OP_CLEAR, 1'b1, 32'd7, 32'd2, 32'd0, 32'd0, 16'd1),
			1'b1, inval});
		dir.push_back('{make_req(OP_CLEAR, 1'b1, 32'd0, 32'd1, 32'd0, 32'd0, 16'd1),
			1'b1, inval});
		// clear of an absent id succeeds
		dir.push_back('{make_req(OP_CLEAR, 1'b1, 32'd5, 32'd1, 32'd0, 32'd0, 16'd0),
			1'b1, okay});
		dir.push_back('{make_req(OP_UPDATE, 1'b1, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 16'hFFFF), 1'b0, none});
		dir.push_back('{make_req(OP_CLASSIFY, 1'b1, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 16'd0),
			1'b0, none});
		dir.push_back('{make_req(OP_CLASSIFY, 1'b0, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 16'd0),
			1'b1, okay});
		dir.push_back('{make_req(OP_UPDATE, 1'b1, 32'hFFFF_FFFF, 32'd1, 32'd0, 32'd0, 16'd1),
			1'b0, none});
		dir.push_back('{make_req(OP_UPDATE, 1'b0, 32'd1, 32'd1, 32'h5555_5555,
			32'hAAAA_AAAA, 16'h8000), 1'b0, none});
		dir.push_back('{make_req(OP_QUERY, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 16'hFFFF), 1'b0, none});
		dir.push_back('{make_req(OP_CLEAR, 1'b1, 32'hFFFF_FFFF, 32'd1, 32'd0, 32'd0, 16'd0),
			1'b0, none});
		dir.push_back('{make_req(OP_CLASSIFY, 1'b1, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 16'd0),
			1'b0, none});
		dir.push_back('{make_req(OP_CLASSIFY, 1'b1, 32'd1, 32'd0, 32'd0, 32'd0, 16'd0),
			1'b0, none});
		dir.push_back('{make_req(OP_QUERY, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 16'd0),
			1'b0, none});

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (k = 0; k < dir.size(); k++)
			issue_request(dir[k].rq, dir[k].typed, dir[k].exp);

		for (phase = 0; phase < PHASES; phase++) begin
			drain();
			repeat (ENTRIES + 6) @(negedge clk);
			case (phase)
			0: begin
				v = 32'hFFFF_FFFF;
				c = 2'd2;
			end
			1: begin
				v = 32'd0;
				c = 2'd1;
			end
			2: begin
				v = 32'd1;
				c = 2'd0;
			end
			default: begin
				v = $urandom();
				c = 2'($urandom_range(0, 2));
			end
			endcase
			write_reg(CFG_VERSION, v);
			write_reg(CFG_CALLOUTS, {30'd0, c});
			sent = 0;
			while (sent < RANDOM_ITEMS / PHASES) begin
				burst = $urandom_range(1, 24);
				repeat (burst) begin
					issue_request(random_request(), 1'b0, none);
					sent++;
				end
				if ($urandom_range(0, 19) == 0) begin
					drain();
				end else if ($urandom_range(0, 2) != 0) begin
					start = 1'b0;
					repeat ($urandom_range(1, 8)) @(negedge clk);
				end
			end
		end

		drain();
		repeat (ENTRIES + 6) @(posedge clk);
		if (failures == 0 && pending_resp.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
